// ===== rtl/psvm_pkg.sv =====
// Shared types and constants of the polyphonic square voice mixer.
package psvm_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NOTE_WAIT,
    S_NOTE_SCAN,
    S_TICK,
    S_SCALE,
    S_OUT
  } psvm_state_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_NOTE = 1'b1
  } psvm_op_t;

  localparam int unsigned MIX_LIMIT   = 127;
  localparam int unsigned FULL_SCALE  = 200000000;
  localparam int unsigned SCALE_Q     = FULL_SCALE / MIX_LIMIT;
  localparam int unsigned SCALE_R     = FULL_SCALE % MIX_LIMIT;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_127   = ((1 << RECIP_SHIFT) + MIX_LIMIT - 1) / MIX_LIMIT;
  localparam int unsigned SCALE_CORR  = SCALE_R * RECIP_127;

  localparam int unsigned MS_PER_S    = 1000;
  localparam int unsigned MS_SHIFT    = 36;
  localparam longint unsigned RECIP_1000 =
    ((64'd1 << MS_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S);

endpackage

// ===== rtl/psvm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module psvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/psvm_span.sv =====
// Note length in samples: floor(length_ms * SAMPLE_RATE_HZ / 1000), two stages.
module psvm_span #(
  parameter int SAMPLE_RATE_HZ = 8000
) (
  input  logic        clk,
  input  logic        load,
  input  logic [15:0] length_ms,
  output logic [31:0] span
);

  localparam logic [5:0]  SR_A = 6'(SAMPLE_RATE_HZ / psvm_pkg::MS_PER_S);
  localparam logic [9:0]  SR_B = 10'(SAMPLE_RATE_HZ % psvm_pkg::MS_PER_S);
  localparam logic [26:0] RECIP = 27'(psvm_pkg::RECIP_1000);

  logic [21:0] prod_a_r;
  logic [25:0] prod_b_r;
  logic [52:0] prod_q;
  logic [31:0] span_r;

  // rate = 1000*A + B; the B part divides by 1000 through a reciprocal
  assign prod_q = 53'(prod_b_r) * 53'(RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      prod_a_r <= 22'(length_ms) * 22'(SR_A);
      prod_b_r <= 26'(length_ms) * 26'(SR_B);
    end
    span_r <= 32'(prod_a_r) + 32'(prod_q[psvm_pkg::MS_SHIFT +: 16]);
  end

  assign span = span_r;

endmodule

// ===== rtl/psvm_scale.sv =====
// Clamp of the voice sum and scaling to full-scale sample, with registered products.
module psvm_scale #(
  parameter int SUM_W = 12
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [SUM_W-1:0] sum,
  output logic signed [28:0]      sample
);

  localparam logic signed [SUM_W-1:0] LIM = SUM_W'(psvm_pkg::MIX_LIMIT);

  logic [6:0]  mag;
  logic        neg_r;
  logic [27:0] hi_r;
  logic [24:0] lo_r;
  logic [27:0] total;

  always_comb begin
    if (sum > LIM || sum < -LIM) begin
      mag = 7'(psvm_pkg::MIX_LIMIT);
    end else if (sum[SUM_W-1]) begin
      mag = 7'(-sum);
    end else begin
      mag = 7'(sum);
    end
  end

  // mag*FULL/127 = mag*Q + floor(mag*R/127)
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= sum[SUM_W-1];
      hi_r  <= 28'(mag) * 28'(psvm_pkg::SCALE_Q);
      lo_r  <= 25'(mag) * 25'(psvm_pkg::SCALE_CORR);
    end
  end

  assign total  = hi_r + 28'(lo_r >> psvm_pkg::RECIP_SHIFT);
  assign sample = neg_r ? -$signed({1'b0, total}) : $signed({1'b0, total});

endmodule

// ===== rtl/polyphonic_square_voice_mixer_unit.sv =====
// Top level of the polyphonic square voice mixer: sequencer, voice RAM, output register.
//
//  channel | valid    | stall     | payload
//  --------+----------+-----------+---------------------------------------------------
//  input   | in_valid | in_stall  | in_operation, in_velocity, in_phase_step,
//          |          |           | in_length_ms
//  result  | out_valid| out_stall | out_sample_value, out_voices_on
//
// Tick: one voice per cycle through the voice RAM read port, then the scaling
// step (S_SCALE) and the output step (S_OUT). Note start: S_NOTE_WAIT, then the scan
// for a free voice. One item at a time; a note start proceeds while a result
// waits, a tick waits at its end for the output register.
// Reset clears active flags, counter and handshakes; the voice RAM needs no clear.
module polyphonic_square_voice_mixer_unit #(
  parameter int VOICES         = 16,
  parameter int SAMPLE_RATE_HZ = 8000,
  parameter int PHASE_BITS     = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic [6:0]         in_velocity,
  input  logic [23:0]        in_phase_step,
  input  logic [15:0]        in_length_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [28:0] out_sample_value,
  output logic               out_voices_on
);

  localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SUM_W = $clog2(VOICES * 127 + 1) + 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(VOICES - 1);

  typedef struct packed {
    logic [6:0]            velocity;
    logic [PHASE_BITS-1:0] phase;
    logic [PHASE_BITS-1:0] step;
    logic [31:0]           end_time;
  } voice_t;

  psvm_pkg::psvm_state_t state_r, state_nxt;

  logic [VOICES-1:0]       act_r, act_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    any_r, any_nxt;
  logic [31:0]             counter_r;
  logic [6:0]              vel_r;
  logic [PHASE_BITS-1:0]   step_r;

  logic                    out_valid_r;
  logic signed [28:0]      out_sample_r;
  logic                    out_any_r;

  logic                    accept;
  logic                    out_load;
  logic                    note_wr;
  logic                    scale_en;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [IDX_W-1:0]        ram_raddr;
  voice_t                  ram_wdata;
  voice_t                  cur;
  logic [31:0]             span;
  logic signed [28:0]      sample;
  logic signed [SUM_W-1:0] vel_ext;

  assign in_stall = (state_r != psvm_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state_r == psvm_pkg::S_OUT) && (!out_valid_r || !out_stall);
  assign vel_ext  = SUM_W'(cur.velocity);

  psvm_ram #(
    .WIDTH ($bits(voice_t)),
    .DEPTH (VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (cur)
  );

  psvm_span #(
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
  ) u_span (
    .clk       (clk),
    .load      (accept),
    .length_ms (in_length_ms),
    .span      (span)
  );

  psvm_scale #(
    .SUM_W (SUM_W)
  ) u_scale (
    .clk    (clk),
    .en     (scale_en),
    .sum    (sum_r),
    .sample (sample)
  );

  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    any_nxt   = any_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_raddr = '0;
    ram_wdata = cur;
    note_wr   = 1'b0;
    scale_en  = 1'b0;
    unique case (state_r)
      psvm_pkg::S_IDLE: begin
        idx_nxt = '0;
        sum_nxt = '0;
        any_nxt = 1'b0;
        if (accept) begin
          if (in_operation == psvm_pkg::OP_NOTE) begin
            state_nxt = psvm_pkg::S_NOTE_WAIT;
          end else begin
            state_nxt = psvm_pkg::S_TICK;
          end
        end
      end
      psvm_pkg::S_NOTE_WAIT: begin
        state_nxt = psvm_pkg::S_NOTE_SCAN;
      end
      psvm_pkg::S_NOTE_SCAN: begin
        ram_wdata.velocity = vel_r;
        ram_wdata.phase    = '0;
        ram_wdata.step     = step_r;
        ram_wdata.end_time = counter_r + span;
        if (!act_r[idx_r]) begin
          note_wr = 1'b1;
        end else if (idx_r == LAST) begin
          note_wr   = 1'b1;
          ram_waddr = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
        if (note_wr) begin
          ram_we             = 1'b1;
          act_nxt[ram_waddr] = 1'b1;
          state_nxt          = psvm_pkg::S_IDLE;
        end
      end
      psvm_pkg::S_TICK: begin
        ram_raddr = (idx_r == LAST) ? '0 : idx_r + 1'b1;
        if (act_r[idx_r]) begin
          if (counter_r >= cur.end_time) begin
            act_nxt[idx_r] = 1'b0;
          end else begin
            sum_nxt         = cur.phase[PHASE_BITS-1] ? sum_r - vel_ext : sum_r + vel_ext;
            any_nxt         = 1'b1;
            ram_wdata.phase = cur.phase + cur.step;
            ram_we          = 1'b1;
          end
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST) begin
          state_nxt = psvm_pkg::S_SCALE;
        end
      end
      psvm_pkg::S_SCALE: begin
        scale_en  = 1'b1;
        state_nxt = psvm_pkg::S_OUT;
      end
      psvm_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = psvm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = psvm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= psvm_pkg::S_IDLE;
      act_r     <= '0;
      counter_r <= '0;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
      if (out_load) begin
        counter_r <= counter_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    sum_r <= sum_nxt;
    any_r <= any_nxt;
    if (accept) begin
      vel_r  <= in_velocity;
      step_r <= PHASE_BITS'(in_phase_step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= sample;
      out_any_r    <= any_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_sample_r;
  assign out_voices_on    = out_any_r;

  a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == psvm_pkg::S_OUT))
    else $error("result register loaded outside the output step");

  a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> counter_r == $past(counter_r) + 32'd1)
    else $error("sample counter did not advance with the result");

  a_any_matches_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psvm_pkg::S_OUT) |-> (any_r == (act_r != '0)))
    else $error("any-active flag disagrees with voice state");

  a_note_claims_voice: assert property (@(posedge clk) disable iff (!rst_n)
    note_wr |=> act_r != '0)
    else $error("note start left no voice active");

endmodule
